### rtl/tcpe_pkg.sv
// ----------------------------------------------------------------------------
// tcpe_pkg: shared types and constants for the TCP connection endpoint
// Commands, connection states, status codes, register map and item structs.
// ----------------------------------------------------------------------------
package tcpe_pkg;

  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  localparam logic [7:0]  PROTO_RESET  = 8'd6;
  localparam logic [15:0] WINDOW_RESET = 16'd1500;

  typedef enum logic [1:0] {
    CMD_CONNECT  = 2'd0,
    CMD_SEGMENT  = 2'd1,
    CMD_SEND     = 2'd2,
    CMD_RESERVED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CS_UNCONNECTED   = 2'd0,
    CS_CONNECTING    = 2'd1,
    CS_CONNECTED     = 2'd2,
    CS_DISCONNECTING = 2'd3
  } conn_state_t;

  typedef enum logic [1:0] {
    STAT_OK            = 2'd0,
    STAT_REJECTED      = 2'd1,
    STAT_NOT_CONNECTED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_LOCAL_PORT  = 2'd0,
    REG_REMOTE_PORT = 2'd1,
    REG_PROTOCOL    = 2'd2,
    REG_WINDOW      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [7:0]  protocol_number;
    logic [15:0] window_size;
  } cfg_t;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  seg_protocol;
    logic [15:0] seg_src_port;
    logic [15:0] seg_dst_port;
    logic [31:0] seg_seq;
    logic        seg_syn;
    logic        seg_ack_flag;
    logic        seg_fin;
    logic [15:0] payload_len;
  } in_item_t;

  typedef struct packed {
    logic        emit_segment;
    logic [31:0] out_seq;
    logic [31:0] out_ack_num;
    logic        out_syn;
    logic        out_ack_bit;
    logic        queue_payload;
    status_t     status;
    conn_state_t conn_state_out;
  } out_item_t;

endpackage

### rtl/tcpe_if.sv
// ----------------------------------------------------------------------------
// tcpe_if: valid/ready channels of the TCP connection endpoint
// Command channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface tcpe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  seg_protocol;
  logic [15:0] seg_src_port;
  logic [15:0] seg_dst_port;
  logic [31:0] seg_seq;
  logic        seg_syn;
  logic        seg_ack_flag;
  logic        seg_fin;
  logic [15:0] payload_len;

  modport source (output valid, command, seg_protocol, seg_src_port, seg_dst_port,
                  seg_seq, seg_syn, seg_ack_flag, seg_fin, payload_len, input ready);
  modport sink   (input valid, command, seg_protocol, seg_src_port, seg_dst_port,
                  seg_seq, seg_syn, seg_ack_flag, seg_fin, payload_len, output ready);
  modport mon    (input valid, ready, command, seg_protocol, seg_src_port, seg_dst_port,
                  seg_seq, seg_syn, seg_ack_flag, seg_fin, payload_len);
endinterface

interface tcpe_out_if;
  logic        valid;
  logic        ready;
  logic        emit_segment;
  logic [31:0] out_seq;
  logic [31:0] out_ack_num;
  logic        out_syn;
  logic        out_ack_bit;
  logic        queue_payload;
  logic [1:0]  status;
  logic [1:0]  conn_state_out;

  modport source (output valid, emit_segment, out_seq, out_ack_num, out_syn, out_ack_bit,
                  queue_payload, status, conn_state_out, input ready);
  modport sink   (input valid, emit_segment, out_seq, out_ack_num, out_syn, out_ack_bit,
                  queue_payload, status, conn_state_out, output ready);
  modport mon    (input valid, ready, emit_segment, out_seq, out_ack_num, out_syn,
                  out_ack_bit, queue_payload, status, conn_state_out);
endinterface

### rtl/tcpe_cfg_regs.sv
// ----------------------------------------------------------------------------
// tcpe_cfg_regs: APB-style configuration registers
// Ports, protocol number and window; zero-wait writes and reads.
// ----------------------------------------------------------------------------
module tcpe_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcpe_pkg::CFG_AW-1:0] paddr,
  input  logic [tcpe_pkg::CFG_DW-1:0] pwdata,
  output logic [tcpe_pkg::CFG_DW-1:0] prdata,
  output tcpe_pkg::cfg_t             cfg
);
  import tcpe_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;

  // word index; the low address bits are ignored
  assign idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_LOCAL_PORT:  cfg_nxt.local_port      = pwdata[15:0];
        REG_REMOTE_PORT: cfg_nxt.remote_port     = pwdata[15:0];
        REG_PROTOCOL:    cfg_nxt.protocol_number = pwdata[7:0];
        REG_WINDOW:      cfg_nxt.window_size     = pwdata[15:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_port      <= '0;
      cfg_r.remote_port     <= '0;
      cfg_r.protocol_number <= PROTO_RESET;
      cfg_r.window_size     <= WINDOW_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_LOCAL_PORT:  prdata = {16'd0, cfg_r.local_port};
      REG_REMOTE_PORT: prdata = {16'd0, cfg_r.remote_port};
      REG_PROTOCOL:    prdata = {24'd0, cfg_r.protocol_number};
      REG_WINDOW:      prdata = {16'd0, cfg_r.window_size};
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

### rtl/tcpe_conn.sv
// ----------------------------------------------------------------------------
// tcpe_conn: connection state and per-item result logic
// Holds state, send and ack numbers; updates them when an item retires.
// ----------------------------------------------------------------------------
module tcpe_conn (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  tcpe_pkg::cfg_t       cfg,
  input  tcpe_pkg::in_item_t   item,
  output tcpe_pkg::out_item_t  res
);
  import tcpe_pkg::*;

  conn_state_t state_r, state_nxt;
  logic [31:0] send_seq_r, send_seq_nxt;
  logic [31:0] recv_ack_r, recv_ack_nxt;

  logic        match;
  logic [31:0] ack_calc;

  assign match = (item.seg_protocol == cfg.protocol_number) &&
                 (item.seg_dst_port == cfg.local_port) &&
                 (item.seg_src_port == cfg.remote_port);
  assign ack_calc = item.seg_seq + {16'd0, item.payload_len} + 32'd1;

  // next state
  always_comb begin
    state_nxt    = state_r;
    send_seq_nxt = send_seq_r;
    recv_ack_nxt = recv_ack_r;
    case (item.command)
      CMD_CONNECT: begin
        state_nxt    = CS_CONNECTING;
        send_seq_nxt = 32'd1;
        recv_ack_nxt = '0;
      end
      CMD_SEGMENT: begin
        if (match && state_r == CS_CONNECTING && item.seg_syn && item.seg_ack_flag) begin
          state_nxt    = CS_CONNECTED;
          recv_ack_nxt = ack_calc;
        end else if (match && state_r == CS_CONNECTED) begin
          recv_ack_nxt = ack_calc;
          if (item.seg_fin) state_nxt = CS_DISCONNECTING;
        end
      end
      CMD_SEND: begin
        if (state_r == CS_CONNECTED) send_seq_nxt = send_seq_r + {16'd0, item.payload_len};
      end
      default: ;
    endcase
  end

  // result item
  always_comb begin
    res                = '0;
    res.status         = STAT_OK;
    res.conn_state_out = state_nxt;
    case (item.command)
      CMD_CONNECT: begin
        res.emit_segment = 1'b1;
        res.out_syn      = 1'b1;
      end
      CMD_SEGMENT: begin
        if (!match) begin
          res.status = STAT_REJECTED;
        end else if ((state_r == CS_CONNECTING && item.seg_syn && item.seg_ack_flag) ||
                     state_r == CS_CONNECTED) begin
          res.emit_segment  = 1'b1;
          res.out_seq       = send_seq_r;
          res.out_ack_num   = ack_calc;
          res.out_ack_bit   = 1'b1;
          res.queue_payload = (state_r == CS_CONNECTED) && (item.payload_len != 16'd0);
        end
      end
      CMD_SEND: begin
        if (state_r == CS_CONNECTED) begin
          res.emit_segment = 1'b1;
          res.out_seq      = send_seq_r;
          res.out_ack_num  = recv_ack_r;
          res.out_ack_bit  = 1'b1;
        end else begin
          res.status = STAT_NOT_CONNECTED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= CS_UNCONNECTED;
      send_seq_r <= '0;
      recv_ack_r <= '0;
    end else if (advance) begin
      state_r    <= state_nxt;
      send_seq_r <= send_seq_nxt;
      recv_ack_r <= recv_ack_nxt;
    end
  end

endmodule

### rtl/tcp_minimal_connection_endpoint.sv
// ----------------------------------------------------------------------------
// tcp_minimal_connection_endpoint: single-connection TCP header endpoint
// Connect / receive segment / send commands in, one header result out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  - command items (connect, received segment header, send request),
//            valid/ready, taken when both are high.
//   out_ch - one result item per command: emitted header fields, queue flag,
//            status and connection state after the command.
//   APB    - local_port, remote_port, protocol_number, window_size at byte
//            addresses 0, 4, 8, 12; zero wait states, reads return the value.
//            Write only while no item is in flight.
// Pipeline: two register stages; an accepted item waits in the input register and
//   moves into the result register, shown on out_ch, when that is free or taken.
// Throughput: one item per cycle while out_ch.ready stays high; the only loop is
//   the connection state and the 32-bit ack/seq adders feeding their registers.
// Reset: connection goes unconnected, both sequence numbers zero, registers
//   to defaults (protocol 6, window 1500), both item registers emptied.
// Stall: a result held on out_ch keeps the input register full; in_ch.ready
//   drops only when both registers hold items, so nothing is lost.
// ----------------------------------------------------------------------------
module tcp_minimal_connection_endpoint (
  input  logic                        clk,
  input  logic                        rst_n,
  tcpe_in_if.sink                     in_ch,
  tcpe_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcpe_pkg::CFG_AW-1:0] paddr,
  input  logic [tcpe_pkg::CFG_DW-1:0] pwdata,
  output logic [tcpe_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import tcpe_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t res;
  out_item_t out_item_r;
  logic      out_valid_r;
  logic      advance;

  assign pready = 1'b1;

  tcpe_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // item in the input register retires into the result register
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_ch.valid || (in_valid_r && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.command      <= cmd_t'(in_ch.command);
      in_item_r.seg_protocol <= in_ch.seg_protocol;
      in_item_r.seg_src_port <= in_ch.seg_src_port;
      in_item_r.seg_dst_port <= in_ch.seg_dst_port;
      in_item_r.seg_seq      <= in_ch.seg_seq;
      in_item_r.seg_syn      <= in_ch.seg_syn;
      in_item_r.seg_ack_flag <= in_ch.seg_ack_flag;
      in_item_r.seg_fin      <= in_ch.seg_fin;
      in_item_r.payload_len  <= in_ch.payload_len;
    end
  end

  tcpe_conn u_conn (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cfg     (cfg),
    .item    (in_item_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= advance || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_item_r <= res;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.emit_segment   = out_item_r.emit_segment;
  assign out_ch.out_seq        = out_item_r.out_seq;
  assign out_ch.out_ack_num    = out_item_r.out_ack_num;
  assign out_ch.out_syn        = out_item_r.out_syn;
  assign out_ch.out_ack_bit    = out_item_r.out_ack_bit;
  assign out_ch.queue_payload  = out_item_r.queue_payload;
  assign out_ch.status         = out_item_r.status;
  assign out_ch.conn_state_out = out_item_r.conn_state_out;

endmodule

### rtl/tcpe_checker.sv
// ----------------------------------------------------------------------------
// tcpe_checker: port-level checks for the TCP connection endpoint
// Reset, stall hold and result field consistency; bound to the top level.
// ----------------------------------------------------------------------------
module tcpe_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_emit_segment,
  input  logic [31:0] out_seq,
  input  logic [31:0] out_ack_num,
  input  logic        out_syn,
  input  logic        out_ack_bit,
  input  logic        out_queue_payload,
  input  logic [1:0]  out_status,
  input  logic [1:0]  out_conn_state
);
  import tcpe_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_seq) && $stable(out_ack_num) &&
      $stable(out_status) && $stable(out_conn_state))
    else $error("stalled result changed");

  a_no_emit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_emit_segment |->
      out_seq == 32'd0 && out_ack_num == 32'd0 &&
      !out_syn && !out_ack_bit)
    else $error("header fields set without emitted segment");

  a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |->
      !out_emit_segment && !out_queue_payload)
    else $error("segment emitted on error status");

  a_syn_connecting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_syn |->
      out_seq == 32'd0 && out_ack_num == 32'd0 &&
      out_conn_state == CS_CONNECTING && !out_ack_bit)
    else $error("SYN result inconsistent");

endmodule

bind tcp_minimal_connection_endpoint tcpe_checker u_tcpe_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_emit_segment  (out_ch.emit_segment),
  .out_seq           (out_ch.out_seq),
  .out_ack_num       (out_ch.out_ack_num),
  .out_syn           (out_ch.out_syn),
  .out_ack_bit       (out_ch.out_ack_bit),
  .out_queue_payload (out_ch.queue_payload),
  .out_status        (out_ch.status),
  .out_conn_state    (out_ch.conn_state_out)
);

### verif/tcpe_scoreboard.sv
// ----------------------------------------------------------------------------
// tcpe_scoreboard: result checker for the TCP connection endpoint
// Mirrors the APB registers, predicts the result of every command item
// accepted on the input channel and compares each result item against the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tcpe_scoreboard (
  input  logic                        clk,
  input  logic                        rst_n,
  tcpe_in_if.mon                      cmd_mon,
  tcpe_out_if.mon                     res_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [tcpe_pkg::CFG_AW-1:0] paddr,
  input  logic [tcpe_pkg::CFG_DW-1:0] pwdata,
  output int                          fail_count,
  output int                          pending
);
  import tcpe_pkg::*;

  cfg_t        regs;
  conn_state_t conn;
  logic [31:0] snd_seq;
  logic [31:0] rcv_ack;
  out_item_t   hdr_q[$];

  // Advances the connection by one command, returns the header it causes.
  function automatic out_item_t step_connection(input in_item_t c);
    out_item_t r;
    r = '0;
    case (c.command)
      CMD_CONNECT: begin
        rcv_ack        = '0;
        r.emit_segment = 1'b1;
        r.out_syn      = 1'b1;
        snd_seq        = 32'd1;
        conn           = CS_CONNECTING;
      end
      CMD_SEGMENT: begin
        if (c.seg_protocol != regs.protocol_number || c.seg_dst_port != regs.local_port ||
            c.seg_src_port != regs.remote_port) begin
          r.status = STAT_REJECTED;
        end else if (conn == CS_CONNECTING) begin
          if (c.seg_syn && c.seg_ack_flag) begin
            conn    = CS_CONNECTED;
            rcv_ack = c.seg_seq + 32'(c.payload_len) + 32'd1;
            r.emit_segment = 1'b1;
            r.out_seq      = snd_seq;
            r.out_ack_num  = rcv_ack;
            r.out_ack_bit  = 1'b1;
          end
        end else if (conn == CS_CONNECTED) begin
          r.queue_payload = (c.payload_len != 16'd0);
          rcv_ack         = c.seg_seq + 32'(c.payload_len) + 32'd1;
          r.emit_segment  = 1'b1;
          r.out_seq       = snd_seq;
          r.out_ack_num   = rcv_ack;
          r.out_ack_bit   = 1'b1;
          if (c.seg_fin) conn = CS_DISCONNECTING;
        end
      end
      CMD_SEND: begin
        if (conn == CS_CONNECTED) begin
          r.emit_segment = 1'b1;
          r.out_seq      = snd_seq;
          r.out_ack_num  = rcv_ack;
          r.out_ack_bit  = 1'b1;
          snd_seq        = snd_seq + 32'(c.payload_len);
        end else begin
          r.status = STAT_NOT_CONNECTED;
        end
      end
      default: ;
    endcase
    r.conn_state_out = conn;
    return r;
  endfunction

  function automatic string diff_fields(input out_item_t e, input out_item_t g);
    string s = "";
    if (e.emit_segment !== g.emit_segment)     s = {s, " emit_segment"};
    if (e.out_seq !== g.out_seq)               s = {s, " out_seq"};
    if (e.out_ack_num !== g.out_ack_num)       s = {s, " out_ack_num"};
    if (e.out_syn !== g.out_syn)               s = {s, " out_syn"};
    if (e.out_ack_bit !== g.out_ack_bit)       s = {s, " out_ack_bit"};
    if (e.queue_payload !== g.queue_payload)   s = {s, " queue_payload"};
    if (e.status !== g.status)                 s = {s, " status"};
    if (e.conn_state_out !== g.conn_state_out) s = {s, " conn_state_out"};
    return s;
  endfunction

  function automatic string fmt_hdr(input out_item_t h);
    return $sformatf("emit=%b seq=%h ack=%h syn=%b ackb=%b queue=%b status=%0d state=%0d",
                     h.emit_segment, h.out_seq, h.out_ack_num, h.out_syn, h.out_ack_bit,
                     h.queue_payload, h.status, h.conn_state_out);
  endfunction

  // fail_count and pending start at zero as int variables
  always @(posedge clk) begin : watch
    in_item_t  c;
    out_item_t got;
    out_item_t want;
    string     bad;
    if (!rst_n) begin
      regs    = '{local_port: '0, remote_port: '0, protocol_number: PROTO_RESET,
                  window_size: WINDOW_RESET};
      conn    = CS_UNCONNECTED;
      snd_seq = '0;
      rcv_ack = '0;
      hdr_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_LOCAL_PORT:  regs.local_port      = pwdata[15:0];
          REG_REMOTE_PORT: regs.remote_port     = pwdata[15:0];
          REG_PROTOCOL:    regs.protocol_number = pwdata[7:0];
          REG_WINDOW:      regs.window_size     = pwdata[15:0];
          default: ;
        endcase
      end
      // input first: a result taken in the same cycle always belongs to an older item
      if (cmd_mon.valid === 1'b1 && cmd_mon.ready === 1'b1) begin
        c.command      = cmd_t'(cmd_mon.command);
        c.seg_protocol = cmd_mon.seg_protocol;
        c.seg_src_port = cmd_mon.seg_src_port;
        c.seg_dst_port = cmd_mon.seg_dst_port;
        c.seg_seq      = cmd_mon.seg_seq;
        c.seg_syn      = cmd_mon.seg_syn;
        c.seg_ack_flag = cmd_mon.seg_ack_flag;
        c.seg_fin      = cmd_mon.seg_fin;
        c.payload_len  = cmd_mon.payload_len;
        hdr_q.push_back(step_connection(c));
      end
      if (res_mon.valid === 1'b1 && res_mon.ready === 1'b1) begin
        got.emit_segment   = res_mon.emit_segment;
        got.out_seq        = res_mon.out_seq;
        got.out_ack_num    = res_mon.out_ack_num;
        got.out_syn        = res_mon.out_syn;
        got.out_ack_bit    = res_mon.out_ack_bit;
        got.queue_payload  = res_mon.queue_payload;
        got.status         = status_t'(res_mon.status);
        got.conn_state_out = conn_state_t'(res_mon.conn_state_out);
        if (hdr_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result item: %s", fmt_hdr(got));
        end else begin
          want = hdr_q.pop_front();
          bad  = diff_fields(want, got);
          if (bad != "") begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result mismatch in%s", bad);
              $display("  expected %s", fmt_hdr(want));
              $display("  actual   %s", fmt_hdr(got));
            end
          end
        end
      end
    end
    pending = hdr_q.size();
  end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for tcp_minimal_connection_endpoint
// Directed corner items, then random connection sessions under several
// register settings and idle patterns; checking lives in tcpe_scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  import tcpe_pkg::*;

  localparam int LIMIT = 400000;   // cycles

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int cycles;
  int n_sent;
  int snd_idle;      // percent of cycles the sender holds back
  int rcv_idle;      // percent of cycles the receiver stalls
  cfg_t cur_cfg;     // what was last written, used to build matching segments

  tcpe_in_if  cmd_ch ();
  tcpe_out_if res_ch ();

  tcp_minimal_connection_endpoint dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (cmd_ch),
    .out_ch  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tcpe_scoreboard chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_mon    (cmd_ch),
    .res_mon    (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog; cycles starts at zero as an int
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // -- item builders --------------------------------------------------------

  // lengths: mostly zero or short, sometimes the max, sometimes anything
  function automatic logic [15:0] rand_len();
    int k;
    k = $urandom_range(99);
    if (k < 25) return 16'd0;
    if (k < 35) return 16'hFFFF;
    if (k < 70) return 16'($urandom_range(64, 1));
    return 16'($urandom);
  endfunction

  // sequence numbers: some just below the wrap point
  function automatic logic [31:0] rand_seq();
    if ($urandom_range(99) < 12) return 32'hFFFF_0000 | 32'($urandom_range(16'hFFFF));
    return $urandom;
  endfunction

  // fully random item, any command including the reserved one
  function automatic in_item_t noise_cmd();
    in_item_t c;
    c.command      = cmd_t'($urandom_range(3));
    c.seg_protocol = 8'($urandom);
    c.seg_src_port = 16'($urandom);
    c.seg_dst_port = 16'($urandom);
    c.seg_seq      = $urandom;
    c.seg_syn      = 1'($urandom);
    c.seg_ack_flag = 1'($urandom);
    c.seg_fin      = 1'($urandom);
    c.payload_len  = 16'($urandom);
    return c;
  endfunction

  // received segment that passes the protocol and port checks
  function automatic in_item_t good_seg(input logic syn, input logic ack, input logic fin);
    in_item_t c;
    c              = noise_cmd();
    c.command      = CMD_SEGMENT;
    c.seg_protocol = cur_cfg.protocol_number;
    c.seg_src_port = cur_cfg.remote_port;
    c.seg_dst_port = cur_cfg.local_port;
    c.seg_seq      = rand_seq();
    c.seg_syn      = syn;
    c.seg_ack_flag = ack;
    c.seg_fin      = fin;
    c.payload_len  = rand_len();
    return c;
  endfunction

  // break exactly one of the three match fields
  function automatic in_item_t spoil(input in_item_t c);
    case ($urandom_range(2))
      0: c.seg_protocol ^= 8'($urandom_range(255, 1));
      1: c.seg_src_port ^= 16'($urandom_range(16'hFFFF, 1));
      default: c.seg_dst_port ^= 16'($urandom_range(16'hFFFF, 1));
    endcase
    return c;
  endfunction

  function automatic in_item_t op_cmd(input cmd_t op, input logic [15:0] len);
    in_item_t c;
    c             = noise_cmd();
    c.command     = op;
    c.payload_len = len;
    return c;
  endfunction

  // -- drivers --------------------------------------------------------------

  // called at a falling edge, returns at a falling edge after the handshake
  task automatic send_cmd(input in_item_t c);
    if ($urandom_range(99) < snd_idle) begin
      cmd_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < snd_idle);
    end
    cmd_ch.command      <= c.command;
    cmd_ch.seg_protocol <= c.seg_protocol;
    cmd_ch.seg_src_port <= c.seg_src_port;
    cmd_ch.seg_dst_port <= c.seg_dst_port;
    cmd_ch.seg_seq      <= c.seg_seq;
    cmd_ch.seg_syn      <= c.seg_syn;
    cmd_ch.seg_ack_flag <= c.seg_ack_flag;
    cmd_ch.seg_fin      <= c.seg_fin;
    cmd_ch.payload_len  <= c.payload_len;
    cmd_ch.valid        <= 1'b1;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    @(negedge clk);
    n_sent++;
  endtask

  // stop sending until every outstanding result has come back
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_LOCAL_PORT:  cur_cfg.local_port      = val[15:0];
      REG_REMOTE_PORT: cur_cfg.remote_port     = val[15:0];
      REG_PROTOCOL:    cur_cfg.protocol_number = val[7:0];
      REG_WINDOW:      cur_cfg.window_size     = val[15:0];
      default: ;
    endcase
  endtask

  // only called with the block idle
  task automatic set_regs(input logic [15:0] lport, input logic [15:0] rport,
                          input logic [7:0] proto, input logic [15:0] win);
    cfg_write(REG_LOCAL_PORT, 32'(lport));
    cfg_write(REG_REMOTE_PORT, 32'(rport));
    cfg_write(REG_PROTOCOL, 32'(proto));
    cfg_write(REG_WINDOW, 32'(win));
  endtask

  // One connection lifetime: connect, handshake, traffic, maybe FIN and
  // leftovers. A few sessions are pure noise or never complete the handshake.
  task automatic run_session();
    in_item_t c;
    int       k;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(4, 1)) send_cmd(noise_cmd());
      return;
    end
    send_cmd(op_cmd(CMD_CONNECT, rand_len()));
    if ($urandom_range(99) < 20) begin
      // half-open handshake noise: mismatched or missing SYN/ACK
      c = good_seg(1'($urandom), 1'b0, 1'($urandom));
      if ($urandom_range(1)) c = spoil(good_seg(1'b1, 1'b1, 1'b0));
      send_cmd(c);
    end
    if ($urandom_range(99) < 90) send_cmd(good_seg(1'b1, 1'b1, 1'($urandom)));
    repeat ($urandom_range(14, 1)) begin
      k = $urandom_range(99);
      if (k < 40)      send_cmd(good_seg(1'($urandom), 1'($urandom),
                                         $urandom_range(99) < 8));
      else if (k < 75) send_cmd(op_cmd(CMD_SEND, rand_len()));
      else if (k < 85) send_cmd(spoil(good_seg(1'($urandom), 1'($urandom), 1'($urandom))));
      else if (k < 88) send_cmd(op_cmd(CMD_CONNECT, rand_len()));
      else             send_cmd(noise_cmd());
    end
  endtask

  task automatic run_random(input int n);
    int target;
    target = n_sent + n;
    while (n_sent < target) run_session();
  endtask

  // -- main sequence --------------------------------------------------------

  initial begin
    in_item_t c;

    // every input known from time zero
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.command      = CMD_CONNECT;
    cmd_ch.seg_protocol = '0;
    cmd_ch.seg_src_port = '0;
    cmd_ch.seg_dst_port = '0;
    cmd_ch.seg_seq      = '0;
    cmd_ch.seg_syn      = 1'b0;
    cmd_ch.seg_ack_flag = 1'b0;
    cmd_ch.seg_fin      = 1'b0;
    cmd_ch.payload_len  = '0;
    n_sent              = 0;
    snd_idle            = 38;
    rcv_idle            = 49;
    cur_cfg = '{local_port: '0, remote_port: '0, protocol_number: PROTO_RESET,
                window_size: WINDOW_RESET};

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners under an ordinary setting
    set_regs(16'd80, 16'd50001, 8'd6, 16'd1500);
    send_cmd(op_cmd(CMD_SEND, 16'd10));                 // send before any connect
    send_cmd(good_seg(1'b1, 1'b1, 1'b0));               // segment while unconnected
    send_cmd(op_cmd(CMD_RESERVED, 16'hFFFF));           // unused command
    send_cmd(op_cmd(CMD_CONNECT, 16'd0));
    send_cmd(good_seg(1'b1, 1'b0, 1'b0));               // SYN without ACK: ignored
    send_cmd(good_seg(1'b0, 1'b1, 1'b1));               // ACK without SYN: ignored
    c = good_seg(1'b1, 1'b1, 1'b0); c.seg_protocol = 8'd17; send_cmd(c);
    c = good_seg(1'b1, 1'b1, 1'b0); c.seg_dst_port = 16'd81; send_cmd(c);
    c = good_seg(1'b1, 1'b1, 1'b0); c.seg_src_port = 16'd0; send_cmd(c);
    // SYN+ACK whose ack number wraps to zero
    c = good_seg(1'b1, 1'b1, 1'b0); c.seg_seq = 32'hFFFF_FFFF; c.payload_len = 16'd0;
    send_cmd(c);
    c = good_seg(1'b0, 1'b1, 1'b0); c.seg_seq = 32'hFFFF_FFF0; c.payload_len = 16'hFFFF;
    send_cmd(c);                                        // payload, wraps
    c = good_seg(1'b0, 1'b0, 1'b0); c.payload_len = 16'd0; send_cmd(c);  // no payload
    send_cmd(op_cmd(CMD_SEND, 16'd0));                  // zero-length send
    send_cmd(op_cmd(CMD_SEND, 16'hFFFF));
    send_cmd(op_cmd(CMD_SEND, 16'd1));
    send_cmd(op_cmd(CMD_RESERVED, 16'd5));              // unused command while connected
    send_cmd(op_cmd(CMD_CONNECT, 16'hFFFF));            // restart from connected
    c = good_seg(1'b1, 1'b1, 1'b1); c.seg_seq = 32'd0; c.payload_len = 16'hFFFF;
    send_cmd(c);
    c = good_seg(1'b0, 1'b1, 1'b1); c.payload_len = 16'd100; send_cmd(c);  // FIN with data
    send_cmd(good_seg(1'b1, 1'b1, 1'b0));               // ignored in disconnecting
    send_cmd(op_cmd(CMD_SEND, 16'd7));                  // not connected
    send_cmd(op_cmd(CMD_CONNECT, 16'd0));               // reconnect from disconnecting
    drain();

    // sender 38 / receiver 49, all fields at their maximum
    set_regs(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    run_random(120);
    drain();                                            // full pause mid-phase
    run_random(115);
    drain();

    // sender 49 / receiver 38, all fields at zero
    snd_idle = 49;
    rcv_idle = 38;
    set_regs(16'h0000, 16'h0000, 8'h00, 16'h0000);
    run_random(235);
    drain();

    // no idling, random ports, standard protocol
    snd_idle = 0;
    rcv_idle = 0;
    set_regs(16'($urandom), 16'($urandom), 8'd6, 16'($urandom));
    run_random(235);
    cmd_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/tcpe_pkg.sv
rtl/tcpe_if.sv
rtl/tcpe_cfg_regs.sv
rtl/tcpe_conn.sv
rtl/tcp_minimal_connection_endpoint.sv
rtl/tcpe_checker.sv
verif/tcpe_scoreboard.sv
verif/testbench.sv
